FILE: rtl/core/nhpk_pkg.sv
// ----------------------------------------------------------------------------
// nhpk_pkg
// Shared types, constants and the saturation helper for the neo-Hookean
// first Piola-Kirchhoff stress pipeline.
// ----------------------------------------------------------------------------
package nhpk_pkg;

  localparam int IN_FIELD_W  = 32;
  localparam int OUT_FIELD_W = 64;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 1'd1;

  localparam logic [CFG_DATA_W-1:0] SHEAR_RST  = 32'd256;
  localparam logic [CFG_DATA_W-1:0] VOLUME_RST = 32'd256;

  // 1.0 in Q.24
  localparam logic [63:0] ONE_Q24 = 64'h0000_0000_0100_0000;
  // alpha for the reset values of shear and volume: 1 + 3/4
  localparam logic [63:0] ALPHA_RST = 64'h0000_0000_01C0_0000;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [IN_FIELD_W-1:0] f_r1_c1;
    logic signed [IN_FIELD_W-1:0] f_r2_c1;
    logic signed [IN_FIELD_W-1:0] f_r3_c1;
    logic signed [IN_FIELD_W-1:0] f_r1_c2;
    logic signed [IN_FIELD_W-1:0] f_r2_c2;
    logic signed [IN_FIELD_W-1:0] f_r3_c2;
    logic signed [IN_FIELD_W-1:0] f_r1_c3;
    logic signed [IN_FIELD_W-1:0] f_r2_c3;
    logic signed [IN_FIELD_W-1:0] f_r3_c3;
  } grad_t;

  typedef struct packed {
    logic signed [OUT_FIELD_W-1:0] p_r1_c1;
    logic signed [OUT_FIELD_W-1:0] p_r2_c1;
    logic signed [OUT_FIELD_W-1:0] p_r3_c1;
    logic signed [OUT_FIELD_W-1:0] p_r1_c2;
    logic signed [OUT_FIELD_W-1:0] p_r2_c2;
    logic signed [OUT_FIELD_W-1:0] p_r3_c2;
    logic signed [OUT_FIELD_W-1:0] p_r1_c3;
    logic signed [OUT_FIELD_W-1:0] p_r2_c3;
    logic signed [OUT_FIELD_W-1:0] p_r3_c3;
    logic                          clipped;
  } stress_t;

  typedef struct packed {
    logic [63:0] val;
    logic        clip;
  } sat_t;

  // clamp a 128-bit signed value to the signed 64-bit range
  function automatic sat_t sat64(input logic signed [127:0] x);
    sat_t r;
    if (x[127:63] == {65{x[63]}}) begin
      r.val  = x[63:0];
      r.clip = 1'b0;
    end else begin
      r.val  = x[127] ? SAT_MIN : SAT_MAX;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/nhpk_dly.sv
// ----------------------------------------------------------------------------
// nhpk_dly
// Fixed-length shift register that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module nhpk_dly #(
  parameter int W = 64,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  // shift one stage per clock
  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < N; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];

endmodule

FILE: rtl/core/nhpk_mul.sv
// ----------------------------------------------------------------------------
// nhpk_mul
// Signed 64x64 multiplier cut into 32-bit partial products, three stages.
// ----------------------------------------------------------------------------
module nhpk_mul (
  input  logic                clk,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic signed [127:0] p
);

  logic        [63:0]  pp_ll;
  logic signed [64:0]  pp_lh;
  logic signed [64:0]  pp_hl;
  logic signed [63:0]  pp_hh;
  logic        [63:0]  ll2;
  logic signed [65:0]  mid2;
  logic signed [63:0]  hh2;

  // stage 1: four partial products
  always_ff @(posedge clk) begin
    pp_ll <= 64'(a[31:0]) * 64'(b[31:0]);
    pp_lh <= 65'($signed({1'b0, a[31:0]})) * 65'($signed(b[63:32]));
    pp_hl <= 65'($signed(a[63:32])) * 65'($signed({1'b0, b[31:0]}));
    pp_hh <= 64'($signed(a[63:32])) * 64'($signed(b[63:32]));
  end

  // stage 2: fold the cross terms
  always_ff @(posedge clk) begin
    ll2  <= pp_ll;
    mid2 <= 66'(pp_lh) + 66'(pp_hl);
    hh2  <= pp_hh;
  end

  // stage 3: final alignment and sum
  always_ff @(posedge clk) begin
    p <= $signed({hh2, 64'd0}) + ($signed(128'(mid2)) <<< 32) + $signed({64'd0, ll2});
  end

endmodule

FILE: rtl/core/nhpk_recip.sv
// ----------------------------------------------------------------------------
// nhpk_recip
// Pipelined restoring divider: q = floor(2^48 / den), one quotient bit per
// stage, for den >= 2^24 so that q fits in 25 bits.
// ----------------------------------------------------------------------------
module nhpk_recip (
  input  logic        clk,
  input  logic [63:0] den,
  output logic [24:0] q
);

  localparam int QW = 25;
  localparam logic [48:0] REM_INIT = 49'h1_0000_0000_0000;

  logic [48:0] rem_r [1:QW];
  logic [63:0] den_r [1:QW];
  logic [QW-1:0] quo_r [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [48:0]   rem_in;
    logic [63:0]   den_in;
    logic [QW-1:0] quo_in;
    logic [88:0]   shifted;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = REM_INIT;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s];
      assign den_in = den_r[s];
      assign quo_in = quo_r[s];
    end

    // trial subtract of the shifted divisor
    assign shifted = {25'd0, den_in} << K;
    assign ge      = {40'd0, rem_in} >= shifted;

    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? (rem_in - shifted[48:0]) : rem_in;
      den_r[s+1] <= den_in;
      quo_r[s+1] <= quo_in | (QW'(ge) << K);
    end
  end

  assign q = quo_r[QW];

endmodule

FILE: rtl/core/neo_hookean_pk1_stress.sv
// ----------------------------------------------------------------------------
// neo_hookean_pk1_stress
// Stable neo-Hookean first Piola-Kirchhoff stress of one 3x3 gradient.
// ----------------------------------------------------------------------------
// Takes one deformation gradient per clock whenever busy is low and returns
// its stress at the end of the pipeline, marked by a one-cycle done strobe; the
// result cannot be held off. The latency is set by the 25-stage reciprocal
// of IC + 1 plus the multiplier stages around it. Every write to a
// configuration register recomputes alpha in a bit-serial divider, which
// raises busy after the write until the division has finished.
module neo_hookean_pk1_stress #(
  parameter int IN_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  nhpk_pkg::grad_t               gradient,
  output logic                          done,
  output nhpk_pkg::stress_t             stress,
  input  logic                          cfg_we,
  input  logic [nhpk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nhpk_pkg::CFG_DATA_W-1:0] cfg_data
);

  import nhpk_pkg::*;

  localparam int PIPE_LAT = 40;

  // --------------------------------------------------------------------------
  // configuration and alpha divider
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {A_IDLE, A_LOAD, A_RUN} astate_t;

  astate_t      astate, astate_next;
  logic [31:0]  shear, volume;
  logic [55:0]  num, num_next;
  logic [32:0]  arem, arem_next;
  logic [55:0]  aquo, aquo_next;
  logic [31:0]  lam_d;
  logic [5:0]   acnt, acnt_next;
  logic [63:0]  alpha, alpha_next;
  logic [33:0]  shear_x3;
  logic [32:0]  rem_sh;

  assign shear_x3 = {2'd0, shear} + {1'b0, shear, 1'b0};
  assign rem_sh   = {arem[31:0], num[55]};

  // one restoring step per cycle
  always_comb begin
    astate_next = astate;
    num_next    = num;
    arem_next   = arem;
    aquo_next   = aquo;
    acnt_next   = acnt;
    alpha_next  = alpha;
    unique case (astate)
      A_IDLE: ;
      A_LOAD: begin
        num_next    = {shear_x3, 22'd0};
        arem_next   = '0;
        aquo_next   = '0;
        acnt_next   = 6'd55;
        astate_next = A_RUN;
      end
      A_RUN: begin
        num_next = {num[54:0], 1'b0};
        if (rem_sh >= {1'b0, lam_d}) begin
          arem_next = rem_sh - {1'b0, lam_d};
          aquo_next = {aquo[54:0], 1'b1};
        end else begin
          arem_next = rem_sh;
          aquo_next = {aquo[54:0], 1'b0};
        end
        acnt_next = acnt - 6'd1;
        if (acnt == 6'd0) begin
          alpha_next  = ONE_Q24 + {8'd0, aquo_next};
          astate_next = A_IDLE;
        end
      end
      default: astate_next = A_IDLE;
    endcase
    if (cfg_we) begin
      astate_next = A_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      shear  <= SHEAR_RST;
      volume <= VOLUME_RST;
      alpha  <= ALPHA_RST;
    end else begin
      astate <= astate_next;
      alpha  <= alpha_next;
      if (cfg_we && cfg_index == REG_SHEAR) begin
        shear <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_VOLUME) begin
        volume <= cfg_data;
      end
    end
    num   <= num_next;
    arem  <= arem_next;
    aquo  <= aquo_next;
    acnt  <= acnt_next;
    lam_d <= (volume == '0) ? 32'd1 : volume;
  end

  assign busy = (astate != A_IDLE);

  // --------------------------------------------------------------------------
  // input register and valid chain
  // --------------------------------------------------------------------------
  logic [31:0]        fin [9];
  logic [63:0]        fz  [9];
  logic signed [63:0] f0  [9];
  logic               vld [0:PIPE_LAT];

  always_comb begin
    fin[0] = gradient.f_r1_c1;
    fin[1] = gradient.f_r2_c1;
    fin[2] = gradient.f_r3_c1;
    fin[3] = gradient.f_r1_c2;
    fin[4] = gradient.f_r2_c2;
    fin[5] = gradient.f_r3_c2;
    fin[6] = gradient.f_r1_c3;
    fin[7] = gradient.f_r2_c3;
    fin[8] = gradient.f_r3_c3;
    for (int i = 0; i < 9; i++) begin
      fz[i] = 64'(fin[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      f0[i] <= 64'($signed(fz[i][IN_WIDTH-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i <= PIPE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stages 1-5: squares, cofactors, IC
  // --------------------------------------------------------------------------
  logic signed [127:0] sq [9];
  logic signed [127:0] cpa [9];
  logic signed [127:0] cpb [9];
  logic signed [63:0]  g4 [9];
  logic [8:0]          cclip;
  logic                c4;
  logic signed [127:0] ics4 [3];
  logic signed [63:0]  ic5;
  logic                c5;
  sat_t                ic_sat;

  for (genvar i = 0; i < 9; i++) begin : g_sq
    nhpk_mul u_sq (.clk(clk), .a(f0[i]), .b(f0[i]), .p(sq[i]));
  end

  // column k of the cofactor is the cross product of the other two columns
  for (genvar k = 0; k < 3; k++) begin : g_cof_col
    localparam int KA = 3 * ((k + 1) % 3);
    localparam int KB = 3 * ((k + 2) % 3);
    for (genvar r = 0; r < 3; r++) begin : g_cof_row
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      nhpk_mul u_pa (.clk(clk), .a(f0[KA+R1]), .b(f0[KB+R2]), .p(cpa[3*k+r]));
      nhpk_mul u_pb (.clk(clk), .a(f0[KA+R2]), .b(f0[KB+R1]), .p(cpb[3*k+r]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      g4[i] <= sat64((cpa[i] - cpb[i]) >>> 24).val;
    end
    for (int j = 0; j < 3; j++) begin
      ics4[j] <= sq[3*j] + sq[3*j+1] + sq[3*j+2];
    end
    c4 <= |cclip;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cclip[i] = sat64((cpa[i] - cpb[i]) >>> 24).clip;
    end
    ic_sat = sat64((ics4[0] + ics4[1] + ics4[2]) >>> 24);
  end

  always_ff @(posedge clk) begin
    ic5 <= ic_sat.val;
    c5  <= c4 | ic_sat.clip;
  end

  // --------------------------------------------------------------------------
  // stages 5-8: determinant from the first column
  // --------------------------------------------------------------------------
  logic signed [63:0]  f4 [9];
  logic signed [63:0]  f36 [9];
  logic signed [63:0]  g36 [9];
  logic signed [127:0] jp [3];
  logic                c7, c8;
  logic signed [63:0]  j8;
  sat_t                j_sat;

  for (genvar i = 0; i < 9; i++) begin : g_fdly
    nhpk_dly #(.W(64), .N(4))  u_f4  (.clk(clk), .d(f0[i]), .q(f4[i]));
    nhpk_dly #(.W(64), .N(32)) u_f36 (.clk(clk), .d(f4[i]), .q(f36[i]));
    nhpk_dly #(.W(64), .N(32)) u_g36 (.clk(clk), .d(g4[i]), .q(g36[i]));
  end

  for (genvar i = 0; i < 3; i++) begin : g_det
    nhpk_mul u_jp (.clk(clk), .a(f4[i]), .b(g4[i]), .p(jp[i]));
  end

  nhpk_dly #(.W(1), .N(2)) u_c7 (.clk(clk), .d(c5), .q(c7));

  assign j_sat = sat64((jp[0] + jp[1] + jp[2]) >>> 24);

  always_ff @(posedge clk) begin
    j8 <= j_sat.val;
    c8 <= c7 | j_sat.clip;
  end

  // --------------------------------------------------------------------------
  // stages 9-13: volume scale s = lambda * (J - alpha)
  // --------------------------------------------------------------------------
  logic signed [127:0] jx, ax;
  sat_t                d_sat, s_sat;
  logic signed [63:0]  d9;
  logic                c9, c12, c13;
  logic signed [127:0] lp12;
  logic signed [63:0]  s13;

  always_comb begin
    jx    = 128'(j8);
    ax    = $signed({64'd0, alpha});
    d_sat = sat64(jx - ax);
    s_sat = sat64(lp12 >>> 8);
  end

  always_ff @(posedge clk) begin
    d9 <= d_sat.val;
    c9 <= c8 | d_sat.clip;
  end

  nhpk_mul u_lam (.clk(clk), .a($signed({32'd0, volume})), .b(d9), .p(lp12));
  nhpk_dly #(.W(1), .N(3)) u_c12 (.clk(clk), .d(c9), .q(c12));

  always_ff @(posedge clk) begin
    s13 <= s_sat.val;
    c13 <= c12 | s_sat.clip;
  end

  // --------------------------------------------------------------------------
  // stages 6-36: shear scale g = mu * (1 - 1/(IC+1))
  // --------------------------------------------------------------------------
  logic [63:0]         den6;
  logic [24:0]         q31;
  logic [24:0]         r32;
  logic signed [127:0] gp35;
  logic signed [63:0]  gs36;
  logic signed [63:0]  s36;
  logic                c36;

  always_ff @(posedge clk) begin
    den6 <= ic5 + ONE_Q24;
  end

  nhpk_recip u_recip (.clk(clk), .den(den6), .q(q31));

  always_ff @(posedge clk) begin
    r32 <= ONE_Q24[24:0] - q31;
  end

  nhpk_mul u_shear (
    .clk(clk),
    .a  ($signed({32'd0, shear})),
    .b  ($signed({39'd0, r32})),
    .p  (gp35)
  );

  always_ff @(posedge clk) begin
    gs36 <= gp35[71:8];
  end

  nhpk_dly #(.W(64), .N(23)) u_s36 (.clk(clk), .d(s13), .q(s36));
  nhpk_dly #(.W(1),  .N(23)) u_c36 (.clk(clk), .d(c13), .q(c36));

  // --------------------------------------------------------------------------
  // stages 37-40: P = (g*F + s*G) / 2^24
  // --------------------------------------------------------------------------
  logic signed [127:0] pa39 [9];
  logic signed [127:0] pb39 [9];
  logic                c39;
  sat_t                p_sat [9];
  logic [63:0]         pv [9];
  logic                pclip;

  for (genvar i = 0; i < 9; i++) begin : g_out
    nhpk_mul u_pa (.clk(clk), .a(gs36), .b(f36[i]), .p(pa39[i]));
    nhpk_mul u_pb (.clk(clk), .a(s36),  .b(g36[i]), .p(pb39[i]));
  end

  nhpk_dly #(.W(1), .N(3)) u_c39 (.clk(clk), .d(c36), .q(c39));

  always_comb begin
    pclip = 1'b0;
    for (int i = 0; i < 9; i++) begin
      p_sat[i] = sat64((pa39[i] + pb39[i]) >>> 24);
      pv[i]    = p_sat[i].val;
      pclip    = pclip | p_sat[i].clip;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    stress.p_r1_c1 <= pv[0];
    stress.p_r2_c1 <= pv[1];
    stress.p_r3_c1 <= pv[2];
    stress.p_r1_c2 <= pv[3];
    stress.p_r2_c2 <= pv[4];
    stress.p_r3_c2 <= pv[5];
    stress.p_r1_c3 <= pv[6];
    stress.p_r2_c3 <= pv[7];
    stress.p_r3_c3 <= pv[8];
    stress.clipped <= c39 | pclip;
  end

  assign done = vld[PIPE_LAT];

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT + 1))
    else $error("result strobe without a matching accepted transaction");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("configuration write did not start the alpha divider");

  a_ic_nonneg: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> !ic5[63])
    else $error("sum of squares went negative");

  a_recip_range: assert property (@(posedge clk) disable iff (rst)
    vld[31] |-> (q31 <= ONE_Q24[24:0]))
    else $error("reciprocal of IC + 1 exceeded one");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// neo_hookean_pk1_stress testbench
// Drives deformation gradients in random bursts across several shear and
// volume settings, predicts each stress tensor with its own fixed-point
// model and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nhpk_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int END_WAIT   = 60;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  grad_t gradient;
  logic done;
  stress_t stress;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  neo_hookean_pk1_stress uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .gradient(gradient),
    .done(done), .stress(stress), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the material registers
  logic [63:0] shear_q8;
  logic [63:0] volume_q8;

  stress_t pending_stress[$];
  int mismatches;
  int burst_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // signed 64 x 64 -> 128
  function automatic logic signed [127:0] wide_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [127:0] ea;
    logic signed [127:0] eb;
    ea = 128'(a);
    eb = 128'(b);
    return ea * eb;
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [127:0] x,
                                                 inout bit clip);
    if (x[127:63] == {65{x[63]}}) return x[63:0];
    clip = 1'b1;
    return x[127] ? SAT_MIN : SAT_MAX;
  endfunction

  function automatic logic signed [63:0] cofactor(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic signed [63:0] c,
                                                  input logic signed [63:0] d,
                                                  inout bit clip);
    return clamp64((wide_mul(a, b) - wide_mul(c, d)) >>> 24, clip);
  endfunction

  function automatic stress_t predict_stress(input grad_t gin);
    logic signed [63:0] f[9];
    logic signed [63:0] g[9];
    logic signed [63:0] ic, jdet, dd, s;
    logic signed [127:0] acc;
    logic [63:0] lam, alpha, den, q, r, gs;
    int ka, kb;
    bit clip;
    stress_t res;
    clip = 1'b0;
    f[0] = 64'(gin.f_r1_c1); f[1] = 64'(gin.f_r2_c1); f[2] = 64'(gin.f_r3_c1);
    f[3] = 64'(gin.f_r1_c2); f[4] = 64'(gin.f_r2_c2); f[5] = 64'(gin.f_r3_c2);
    f[6] = 64'(gin.f_r1_c3); f[7] = 64'(gin.f_r2_c3); f[8] = 64'(gin.f_r3_c3);
    // invariant IC
    acc = '0;
    for (int i = 0; i < 9; i++) acc = acc + wide_mul(f[i], f[i]);
    ic = clamp64(acc >>> 24, clip);
    // cofactor columns from cross products
    for (int k = 0; k < 3; k++) begin
      ka = 3 * ((k + 1) % 3);
      kb = 3 * ((k + 2) % 3);
      g[3*k+0] = cofactor(f[ka+1], f[kb+2], f[ka+2], f[kb+1], clip);
      g[3*k+1] = cofactor(f[ka+2], f[kb+0], f[ka+0], f[kb+2], clip);
      g[3*k+2] = cofactor(f[ka+0], f[kb+1], f[ka+1], f[kb+0], clip);
    end
    // determinant
    acc = '0;
    for (int i = 0; i < 3; i++) acc = acc + wide_mul(f[i], g[i]);
    jdet = clamp64(acc >>> 24, clip);
    // material terms
    lam = (volume_q8 != 0) ? volume_q8 : 64'd1;
    alpha = ONE_Q24 + (64'd3 * shear_q8 * (64'd1 << 22)) / lam;
    den = ic + ONE_Q24;
    q = (64'd1 << 48) / den;
    r = ONE_Q24 - q;
    gs = (shear_q8 * r) >> 8;
    dd = clamp64(wide_mul(jdet, 64'sd0) + jdet - $signed(alpha), clip);
    s = clamp64(wide_mul($signed(volume_q8), dd) >>> 8, clip);
    for (int i = 0; i < 9; i++)
      f[i] = clamp64((wide_mul($signed(gs), f[i]) + wide_mul(s, g[i])) >>> 24, clip);
    res.p_r1_c1 = f[0]; res.p_r2_c1 = f[1]; res.p_r3_c1 = f[2];
    res.p_r1_c2 = f[3]; res.p_r2_c2 = f[4]; res.p_r3_c2 = f[5];
    res.p_r1_c3 = f[6]; res.p_r2_c3 = f[7]; res.p_r3_c3 = f[8];
    res.clipped = clip;
    return res;
  endfunction

  // monitor: record accepted gradients, check returned stress
  always @(posedge clk) begin
    stress_t want;
    if (!rst && start && !busy) pending_stress.push_back(predict_stress(gradient));
    if (!rst && done) begin
      if (pending_stress.size() == 0) begin
        $error("stress transaction with no gradient outstanding");
        mismatches++;
      end else begin
        want = pending_stress.pop_front();
        if (stress.p_r1_c1 !== want.p_r1_c1) begin
          $error("p_r1_c1 exp %h got %h", want.p_r1_c1, stress.p_r1_c1); mismatches++; end
        if (stress.p_r2_c1 !== want.p_r2_c1) begin
          $error("p_r2_c1 exp %h got %h", want.p_r2_c1, stress.p_r2_c1); mismatches++; end
        if (stress.p_r3_c1 !== want.p_r3_c1) begin
          $error("p_r3_c1 exp %h got %h", want.p_r3_c1, stress.p_r3_c1); mismatches++; end
        if (stress.p_r1_c2 !== want.p_r1_c2) begin
          $error("p_r1_c2 exp %h got %h", want.p_r1_c2, stress.p_r1_c2); mismatches++; end
        if (stress.p_r2_c2 !== want.p_r2_c2) begin
          $error("p_r2_c2 exp %h got %h", want.p_r2_c2, stress.p_r2_c2); mismatches++; end
        if (stress.p_r3_c2 !== want.p_r3_c2) begin
          $error("p_r3_c2 exp %h got %h", want.p_r3_c2, stress.p_r3_c2); mismatches++; end
        if (stress.p_r1_c3 !== want.p_r1_c3) begin
          $error("p_r1_c3 exp %h got %h", want.p_r1_c3, stress.p_r1_c3); mismatches++; end
        if (stress.p_r2_c3 !== want.p_r2_c3) begin
          $error("p_r2_c3 exp %h got %h", want.p_r2_c3, stress.p_r2_c3); mismatches++; end
        if (stress.p_r3_c3 !== want.p_r3_c3) begin
          $error("p_r3_c3 exp %h got %h", want.p_r3_c3, stress.p_r3_c3); mismatches++; end
        if (stress.clipped !== want.clipped) begin
          $error("clipped exp %b got %b", want.clipped, stress.clipped); mismatches++; end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // send one gradient, idling between random bursts
  task automatic send_grad(input grad_t gin);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    start <= 1'b1;
    gradient <= gin;
    burst_left--;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    burst_left = 0;
    while (pending_stress.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_SHEAR) shear_q8 = 64'(val);
    else if (idx == REG_VOLUME) volume_q8 = 64'(val);
    cfg_we <= 1'b0;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_material(input logic [31:0] mu, input logic [31:0] lam);
    drain();
    repeat (45) @(posedge clk);
    write_reg(REG_SHEAR, mu);
    write_reg(REG_VOLUME, lam);
  endtask

  function automatic grad_t uniform_grad(input logic signed [31:0] v);
    return {9{v}};
  endfunction

  // near-identity gradient with random perturbation
  function automatic grad_t physical_grad;
    logic [287:0] bits;
    int span;
    span = 1 << $urandom_range(12, 25);
    for (int i = 0; i < 9; i++) begin
      bits[32*i +: 32] = $urandom_range(0, 2 * span) - span;
      if (i == 0 || i == 4 || i == 8) bits[32*i +: 32] += 32'h0100_0000;
    end
    return bits;
  endfunction

  function automatic grad_t random_grad;
    logic [287:0] bits;
    logic [31:0] pick[5];
    pick = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0100_0000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return physical_grad();
      6, 7: for (int i = 0; i < 9; i++) bits[32*i +: 32] = $urandom;
      default: for (int i = 0; i < 9; i++)
        bits[32*i +: 32] = $urandom_range(0, 1) ? pick[$urandom_range(0, 4)] : $urandom;
    endcase
    return bits;
  endfunction

  // extremes of every field, identity, reflection, collapse
  task automatic test_directed;
    grad_t g;
    send_grad('0);
    send_grad(uniform_grad(32'sh7FFF_FFFF));
    send_grad(uniform_grad(32'sh8000_0000));
    send_grad(uniform_grad(-32'sd1));
    g = '0; g.f_r1_c1 = 32'h0100_0000; g.f_r2_c2 = 32'h0100_0000; g.f_r3_c3 = 32'h0100_0000;
    send_grad(g);
    g.f_r1_c1 = -32'sh0100_0000;
    send_grad(g);
    g = '0; g.f_r1_c1 = 32'sh7FFF_FFFF; g.f_r2_c2 = 32'sh7FFF_FFFF; g.f_r3_c3 = 32'sh7FFF_FFFF;
    send_grad(g);
    g.f_r2_c2 = 32'sh8000_0000;
    send_grad(g);
    g = '0; g.f_r1_c2 = 32'sh8000_0000; g.f_r2_c3 = 32'sh8000_0000; g.f_r3_c1 = 32'sh8000_0000;
    send_grad(g);
    g = '0; g.f_r1_c1 = 32'h0080_0000; g.f_r2_c2 = 32'h0080_0000; g.f_r3_c3 = 32'h0080_0000;
    send_grad(g);
    g = {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
         32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    send_grad(g);
    send_grad(~g);
    for (int i = 0; i < 6; i++) send_grad(physical_grad());
  endtask

  task automatic test_random(input int n, input bit hold_once);
    for (int i = 0; i < n; i++) begin
      if (hold_once && i == n / 2) drain();
      send_grad(random_grad());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    gradient = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    burst_left = 0;
    idle_cycles = 0;
    shear_q8 = 64'(SHEAR_RST);
    volume_q8 = 64'(VOLUME_RST);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(150, 1'b1);
    set_material(32'd0, 32'd1);
    test_directed();
    test_random(100, 1'b0);
    set_material(32'hFFFF_FFFF, 32'd1);
    test_random(100, 1'b0);
    set_material(32'd700, 32'd0);
    test_random(100, 1'b0);
    set_material(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_directed();
    test_random(100, 1'b0);
    set_material($urandom, $urandom_range(1, 32'hFFFF_FFFF));
    test_random(100, 1'b0);
    set_material($urandom_range(64, 4096), $urandom_range(64, 65536));
    test_random(100, 1'b0);

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/nhpk_pkg.sv
rtl/core/nhpk_dly.sv
rtl/core/nhpk_mul.sv
rtl/core/nhpk_recip.sv
rtl/core/neo_hookean_pk1_stress.sv
tb/testbench.sv
